### rtl/core/i2a_pkg.sv
`timescale 1ns / 1ps

package i2a_pkg;

  // mode codes on the func field
  localparam logic [1:0] FUNC_SIGNED = 2'd0;
  localparam logic [1:0] FUNC_UDEC   = 2'd1;
  localparam logic [1:0] FUNC_HEXL   = 2'd2;
  localparam logic [1:0] FUNC_HEXU   = 2'd3;

  localparam logic [4:0] BASE_MIN = 5'd2;
  localparam logic [4:0] BASE_DEC = 5'd10;
  localparam logic [4:0] BASE_HEX = 5'd16;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS = 8;

  typedef struct packed {
    logic       neg;
    logic       upper;
    logic [4:0] base;
  } cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_SHOW
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] dd;
    dd = {4'h0, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + dd;
    end
    return (upper ? CHAR_UP_A : CHAR_LOW_A) + dd - 8'd10;
  endfunction

endpackage

### rtl/core/i2a_if.sv
`timescale 1ns / 1ps

interface i2a_in_if #(parameter int VALUE_WIDTH = 32) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             func;
  logic [VALUE_WIDTH-1:0] value;
  logic [4:0]             radix;

  modport source(output valid, func, value, radix, input ready);
  modport sink(input valid, func, value, radix, output ready);
endinterface

interface i2a_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source(output valid, character, last, input ready);
  modport sink(input valid, character, last, output ready);
endinterface

### rtl/core/integer_to_ascii_converter.sv
`timescale 1ns / 1ps

// Integer to ASCII converter.
// din carries one item per number: func (mode), value and radix. dout returns
// the formatted text one character per item, most significant digit first, a
// leading '-' for negative signed values, with last set on the final character.
// The front classifies each item (mode, sign, magnitude, base) and pushes it
// into a two-entry queue, so din keeps accepting while dout is stalled until
// the queue is full. The back divides the magnitude by the base, 8 quotient
// bits per cycle, one full division per digit (ST_DIV); digits go into a
// small RAM and are read back in reverse through the registered read port,
// ST_READ then ST_SHOW per character, with ST_SIGN first for a minus sign.
// At 32 bits the longest text is a minus sign and 31 binary digits.
// A stalled dout holds the current character; the back makes no progress and
// the queue fills, after which din.ready drops.
// Reset (rst, synchronous) empties the queue and returns the back to idle; any
// number in progress is dropped. No state is kept between numbers.
module integer_to_ascii_converter #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  i2a_in_if.sink    din,
  i2a_out_if.source dout
);
  import i2a_pkg::*;

  localparam int QW = VALUE_WIDTH + $bits(cls_t);

  logic                   f_valid;
  logic                   f_ready;
  logic [VALUE_WIDTH-1:0] f_mag;
  cls_t                   f_cls;

  logic                   q_valid;
  logic                   q_ready;
  logic [QW-1:0]          q_data;
  logic [VALUE_WIDTH-1:0] q_mag;
  cls_t                   q_cls;

  i2a_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .din     (din),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_mag   (f_mag),
    .f_cls   (f_cls)
  );

  // descriptor queue between classification and conversion
  i2a_queue #(.DW(QW), .DEPTH(2)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_mag, f_cls}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_mag = q_data[QW-1 -: VALUE_WIDTH];
  assign q_cls = q_data[$bits(cls_t)-1:0];

  i2a_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_mag   (q_mag),
    .q_cls   (q_cls),
    .dout    (dout)
  );

  // an empty queue always has room
  a_empty_has_room : assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> din.ready)
    else $error("queue empty but input not ready");

  // an accepted item is visible to the back on the next cycle
  a_push_seen : assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> q_valid)
    else $error("accepted item missing from queue");

  // the back goes idle after the final character of a number
  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.ready && dout.last |=> !dout.valid)
    else $error("output still valid after final character");

  // a minus sign is never the final character
  a_sign_not_last : assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.character == CHAR_MINUS |-> !dout.last)
    else $error("minus sign marked as final character");

endmodule

### rtl/core/i2a_front.sv
`timescale 1ns / 1ps

module i2a_front #(
  parameter int VALUE_WIDTH = 32
) (
  i2a_in_if.sink                 din,
  output logic                   f_valid,
  input  logic                   f_ready,
  output logic [VALUE_WIDTH-1:0] f_mag,
  output i2a_pkg::cls_t          f_cls
);
  import i2a_pkg::*;

  localparam logic [VALUE_WIDTH-1:0] MOST_NEG = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);

  logic [4:0] clamped;

  assign din.ready = f_ready;
  assign f_valid   = din.valid;

  always_comb begin
    if (din.radix < BASE_MIN) begin
      clamped = BASE_MIN;
    end else if (din.radix > BASE_HEX) begin
      clamped = BASE_HEX;
    end else begin
      clamped = din.radix;
    end
  end

  always_comb begin
    f_mag       = din.value;
    f_cls.neg   = 1'b0;
    f_cls.upper = 1'b0;
    f_cls.base  = BASE_HEX;
    unique case (din.func)
      FUNC_SIGNED: begin
        f_cls.neg = din.value[VALUE_WIDTH-1];
        if (din.value[VALUE_WIDTH-1]) begin
          f_mag = ~din.value + VALUE_WIDTH'(1);
        end
        // most negative value always prints in decimal
        f_cls.base = (din.value == MOST_NEG) ? BASE_DEC : clamped;
      end
      FUNC_UDEC: f_cls.base = BASE_DEC;
      FUNC_HEXL: f_cls.base = BASE_HEX;
      FUNC_HEXU: begin
        f_cls.base  = BASE_HEX;
        f_cls.upper = 1'b1;
      end
      default: f_cls.base = BASE_HEX;
    endcase
  end

endmodule

### rtl/core/i2a_queue.sv
`timescale 1ns / 1ps

module i2a_queue #(
  parameter int DW    = 39,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] entries [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wr_data;
    end
  end

endmodule

### rtl/core/i2a_back.sv
`timescale 1ns / 1ps

module i2a_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  logic [VALUE_WIDTH-1:0] q_mag,
  input  i2a_pkg::cls_t          q_cls,
  i2a_out_if.source              dout
);
  import i2a_pkg::*;

  localparam int STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W = STEPS * DIV_BITS;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int NW    = $clog2(VALUE_WIDTH + 1);
  localparam int AW    = $clog2(VALUE_WIDTH);

  back_state_t state, state_next;

  logic [DIV_W-1:0] work;
  logic [3:0]       rem;
  logic [SW-1:0]    step;
  logic [NW-1:0]    cnt;
  logic [AW-1:0]    idx;
  cls_t             cls;

  logic [DIV_W-1:0] div_work;
  logic [3:0]       div_rem;
  logic             last_step;
  logic             mem_we;

  logic [3:0]       mem [VALUE_WIDTH];
  logic [3:0]       rd_digit;

  // long division by the base, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [4:0]       r;
    logic [DIV_W-1:0] w;
    r = {1'b0, rem};
    w = work;
    for (int j = 0; j < DIV_BITS; j++) begin
      r = {r[3:0], w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (r >= cls.base) begin
        r    = r - cls.base;
        w[0] = 1'b1;
      end
    end
    div_work = w;
    div_rem  = r[3:0];
  end

  assign last_step = (step == SW'(STEPS - 1));
  assign mem_we    = (state == ST_DIV) && last_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    q_ready        = 1'b0;
    dout.valid     = 1'b0;
    dout.character = digit_char(rd_digit, cls.upper);
    dout.last      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step && div_work == '0) begin
          state_next = cls.neg ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        dout.valid     = 1'b1;
        dout.character = CHAR_MINUS;
        if (dout.ready) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_SHOW;
      ST_SHOW: begin
        dout.valid = 1'b1;
        dout.last  = (idx == '0);
        if (dout.ready) begin
          state_next = (idx == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        work <= DIV_W'(q_mag);
        cls  <= q_cls;
        rem  <= '0;
        step <= '0;
        cnt  <= '0;
      end
      ST_DIV: begin
        work <= div_work;
        if (last_step) begin
          rem  <= '0;
          step <= '0;
          cnt  <= cnt + NW'(1);
          idx  <= cnt[AW-1:0];
        end else begin
          rem  <= div_rem;
          step <= step + SW'(1);
        end
      end
      ST_SHOW: begin
        if (dout.ready && idx != '0) begin
          idx <= idx - AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt[AW-1:0]] <= div_rem;
    end
    rd_digit <= mem[idx];
  end

endmodule
